FILE: sv/coq_pkg.sv
`timescale 1ns / 1ps

package coq_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        OUTCOME_UPDATED  = 2'd0,
        OUTCOME_APPENDED = 2'd1,
        OUTCOME_DROPPED  = 2'd2,
        OUTCOME_NONE     = 2'd3
    } outcome_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic hit_any;
    } ctl_t;

endpackage

FILE: sv/coalescing_update_queue.sv
`timescale 1ns / 1ps
// coalescing update queue: fifo of key/value pairs where a push of a key
// already present overwrites that entry's value in place
// input channel: in_valid/in_ready with func (0 push, 1 pop), key, value
// output channel: out_valid/out_ready, one result beat per input beat with
// pop_valid, pop_key, pop_value, push_outcome, now_empty, now_full
// result: registered, it appears in the cycle after the input beat is taken
// throughput: one beat per cycle unless stalled; every cell compares its
// key, on a pop shifts one place, all at once; hit ripples down the row
// stall: a waiting result is held in the output register; a new input beat
// is taken in the cycle the held result is taken, otherwise input waits
// reset: the fill count and output valid clear at once, the queue is empty
// and ready in the first cycle after reset
module coalescing_update_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic        [coq_pkg::KEY_W-1:0]     key,
    input  logic signed [coq_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pop_valid,
    output logic        [coq_pkg::KEY_W-1:0]     pop_key,
    output logic signed [coq_pkg::VALUE_W-1:0]   pop_value,
    output logic        [1:0]                    push_outcome,
    output logic                                 now_empty,
    output logic                                 now_full
);
    import coq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      take;
    logic                      full;
    logic [DEPTH-1:0]          filled;
    logic [DEPTH:0]            hit_w;
    logic [KEY_W-1:0]          cell_key   [DEPTH];
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    ctl_t                      ctl;
    outcome_t                  outcome;

    logic                      out_valid_reg;
    logic                      pop_valid_reg;
    logic [KEY_W-1:0]          pop_key_reg;
    logic signed [VALUE_W-1:0] pop_value_reg;
    outcome_t                  outcome_reg;
    logic                      empty_reg;
    logic                      full_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign full     = (count_reg == FULL_COUNT);

    assign ctl.push    = take && !func;
    assign ctl.pop     = take && func && (count_reg != '0);
    assign ctl.hit_any = hit_w[DEPTH];
    assign hit_w[0]    = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign filled[i] = (CW'(i) < count_reg);

            coq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .filled      (filled[i]),
                .prev_filled ((i == 0) ? 1'b1 : filled[(i == 0) ? 0 : i - 1]),
                .in_key      (key),
                .in_value    (value),
                .next_key    (cell_key[(i == DEPTH - 1) ? i : i + 1]),
                .next_value  (cell_value[(i == DEPTH - 1) ? i : i + 1]),
                .hit_in      (hit_w[i]),
                .hit_out     (hit_w[i+1]),
                .key_reg     (cell_key[i]),
                .value_reg   (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        outcome    = OUTCOME_NONE;
        if (ctl.push)
        begin
            priority if (hit_w[DEPTH])
            begin
                outcome = OUTCOME_UPDATED;
            end
            else if (full)
            begin
                outcome = OUTCOME_DROPPED;
            end
            else
            begin
                outcome    = OUTCOME_APPENDED;
                count_next = count_reg + CW'(1);
            end
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pop_valid_reg <= ctl.pop;
            pop_key_reg   <= ctl.pop ? cell_key[0] : '0;
            pop_value_reg <= ctl.pop ? cell_value[0] : '0;
            outcome_reg   <= outcome;
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next == FULL_COUNT);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pop_valid    = pop_valid_reg;
    assign pop_key      = pop_key_reg;
    assign pop_value    = pop_value_reg;
    assign push_outcome = outcome_reg;
    assign now_empty    = empty_reg;
    assign now_full     = full_reg;

endmodule

FILE: sv/coq_cell.sv
`timescale 1ns / 1ps

module coq_cell (
    input  logic                                 clk,
    input  coq_pkg::ctl_t                        ctl,
    input  logic                                 filled,
    input  logic                                 prev_filled,
    input  logic        [coq_pkg::KEY_W-1:0]     in_key,
    input  logic signed [coq_pkg::VALUE_W-1:0]   in_value,
    input  logic        [coq_pkg::KEY_W-1:0]     next_key,
    input  logic signed [coq_pkg::VALUE_W-1:0]   next_value,
    input  logic                                 hit_in,
    output logic                                 hit_out,
    output logic        [coq_pkg::KEY_W-1:0]     key_reg,
    output logic signed [coq_pkg::VALUE_W-1:0]   value_reg
);
    import coq_pkg::*;

    logic                      match;
    logic                      update;
    logic                      append;
    logic [KEY_W-1:0]          key_next;
    logic signed [VALUE_W-1:0] value_next;

    assign match   = filled && (key_reg == in_key);
    assign hit_out = hit_in || match;
    assign update  = ctl.push && match && !hit_in;
    assign append  = ctl.push && !ctl.hit_any && !filled && prev_filled;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (ctl.pop)
        begin
            key_next   = next_key;
            value_next = next_value;
        end
        else if (append)
        begin
            key_next   = in_key;
            value_next = in_value;
        end
        else if (update)
        begin
            value_next = in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule
